// File: rtl/hsc_pkg.sv
// hsc_pkg: shared widths, register indexes and the cell status struct
// for the horspool substring counter; no dependencies
`default_nettype none

package hsc_pkg;

    localparam int TEXT_W      = 8;
    localparam int COUNT_W     = 32;
    localparam int LEN_W       = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int PAT_WORDS   = 4;
    localparam int WORD_BYTES  = CFG_DATA_W / TEXT_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_0_7    = 3'd1,
        REG_PATTERN_8_15   = 3'd2,
        REG_PATTERN_16_23  = 3'd3,
        REG_PATTERN_24_31  = 3'd4
    } hsc_reg_t;

    // per-cell status handed to the top level
    typedef struct packed {
        logic eq;           // incoming byte equals this cell's pattern byte
        logic prefix_next;  // pattern prefix ending at this cell matches, this beat
        logic prefix;       // registered prefix flag from the previous beat
    } hsc_cell_out_t;

endpackage

`default_nettype wire

// File: rtl/hsc_if.sv
// hsc_if: valid/ready channel interfaces for text bytes, counts and config
// depends on hsc_pkg
`default_nettype none

interface hsc_byte_if import hsc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TEXT_W-1:0] text_byte;
    logic              last_byte;

    modport source (output valid, text_byte, last_byte, input ready);
    modport sink   (input valid, text_byte, last_byte, output ready);
endinterface

interface hsc_count_if import hsc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] match_count;

    modport source (output valid, match_count, input ready);
    modport sink   (input valid, match_count, output ready);
endinterface

interface hsc_cfg_if import hsc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/hsc_cell.sv
// hsc_cell: one pattern position; holds its pattern byte and prefix-match flag
// depends on hsc_pkg
`default_nettype none

module hsc_cell
    import hsc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              start,
    input  wire logic [TEXT_W-1:0] text_byte,
    input  wire logic [TEXT_W-1:0] cfg_byte,
    input  wire logic              prefix_in,
    output hsc_cell_out_t          status
);

    logic [TEXT_W-1:0] pat_reg;
    logic [TEXT_W-1:0] pat_next;
    logic              prefix_reg;
    logic              prefix_next;
    logic              eq;

    // pattern byte is sampled on the first beat of a text
    assign pat_next    = start ? cfg_byte : pat_reg;
    assign eq          = (text_byte == pat_next);
    assign prefix_next = prefix_in & eq;

    assign status.eq          = eq;
    assign status.prefix_next = prefix_next;
    assign status.prefix      = prefix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= 1'b0;
        end
        else if (advance)
        begin
            prefix_reg <= prefix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pat_reg <= pat_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/horspool_substring_counter_core.sv
// horspool_substring_counter_core: counts pattern occurrences in a byte stream
// depends on hsc_pkg, hsc_if and hsc_cell
`default_nettype none

// usage
//   cfg      : register writes (index, data); always ready. index 0 is the
//              pattern length (clamped to PATTERN_MAX), 1..4 hold pattern
//              bytes 0..31, byte 0 in the low bits. unknown indexes are
//              ignored. pattern and length are sampled on the first beat of
//              each text, so writes during a text apply to the next one
//   text_in  : one text byte per beat, last_byte marks the end of a text
//   count_out: one beat per text carrying the saturating match count,
//              overlapping matches included
// latency and throughput
//   one text byte per cycle unless text_in stalls; the count appears the
//   cycle after the last beat. the rate is set by the cell row: every cell
//   compares the new byte with its pattern byte in the same cycle, and the
//   skip counter and the bad-character shift lookup close in that cycle too
// reset
//   clears config, length, count, skip and valid state; the next beat starts a text
// stall
//   a finished count sits in the output register; text beats keep flowing
//   until a count waits and the receiver holds ready low, then text_in
//   stalls until it is taken

module horspool_substring_counter_core
    import hsc_pkg::*;
#(
    parameter int PATTERN_MAX = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    hsc_byte_if.sink    text_in,
    hsc_count_if.source count_out,
    hsc_cfg_if.sink     cfg
);

    localparam int MW = $clog2(PATTERN_MAX + 1);

    // configuration registers
    logic [LEN_W-1:0]      len_reg;
    logic [LEN_W-1:0]      len_next;
    logic [CFG_DATA_W-1:0] pat_word_reg  [PAT_WORDS];
    logic [CFG_DATA_W-1:0] pat_word_next [PAT_WORDS];

    // text state
    logic                  first_reg;
    logic                  first_next;
    logic [MW-1:0]         m_reg;
    logic [MW-1:0]         m_next;
    logic [MW-1:0]         skip_reg;
    logic [MW-1:0]         skip_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;

    // output register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [COUNT_W-1:0]    result_reg;
    logic [COUNT_W-1:0]    result_next;

    logic                  accept;
    logic [MW-1:0]         m_cfg;
    logic [MW-1:0]         m_cur;
    logic [MW-1:0]         skip_cur;
    logic [MW-1:0]         shift_dec;
    logic [MW-1:0]         best_k;
    logic                  found;
    logic                  full;
    logic [COUNT_W-1:0]    count_upd;

    logic [PATTERN_MAX-1:0] prefix_in;
    logic [PATTERN_MAX-1:0] prefix_now;
    logic [PATTERN_MAX-1:0] is_last;
    logic [PATTERN_MAX-1:0] shift_hit;
    hsc_cell_out_t          cell_out [PATTERN_MAX];

    assign accept          = text_in.valid & text_in.ready;
    assign text_in.ready   = ~out_valid_reg | count_out.ready;
    assign count_out.valid = out_valid_reg;
    assign count_out.match_count = result_reg;
    assign cfg.ready       = 1'b1;

    // effective length: registers on the first beat, sampled copy after
    assign m_cfg = (len_reg > LEN_W'(PATTERN_MAX)) ? MW'(PATTERN_MAX) : len_reg[MW-1:0];
    assign m_cur = first_reg ? m_cfg : m_reg;

    // skip counter starts at m-1 at the head of a text
    assign skip_cur = first_reg ? ((m_cur != '0) ? m_cur - MW'(1) : '0) : skip_reg;

    // row of cells: cell k tracks "last k+1 bytes equal pattern[0..k]"
    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            assign prefix_in[k] = 1'b1;
        end
        else
        begin : g_body
            // prefix chain restarts with each text
            assign prefix_in[k] = cell_out[k-1].prefix & ~first_reg;
        end

        hsc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (accept),
            .start     (first_reg),
            .text_byte (text_in.text_byte),
            .cfg_byte  (pat_word_reg[k / WORD_BYTES][(k % WORD_BYTES) * TEXT_W +: TEXT_W]),
            .prefix_in (prefix_in[k]),
            .status    (cell_out[k])
        );

        assign prefix_now[k] = cell_out[k].prefix_next;
        assign is_last[k]    = (m_cur == MW'(k + 1));
        // bad-character table: positions 0..m-2 take part
        assign shift_hit[k]  = cell_out[k].eq & (MW'(k + 1) < m_cur);
    end

    // full pattern match ends at the newest byte
    assign full = |(prefix_now & is_last);

    // rightmost occurrence of the new byte among pattern positions 0..m-2
    always_comb
    begin
        found  = 1'b0;
        best_k = '0;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if (shift_hit[k])
            begin
                found  = 1'b1;
                best_k = MW'(k);
            end
        end
    end

    // shift minus one: m-2-k on a hit, m-1 otherwise
    assign shift_dec = found ? (m_cur - best_k - MW'(2)) : (m_cur - MW'(1));

    // configuration writes
    always_comb
    begin
        len_next      = len_reg;
        pat_word_next = pat_word_reg;
        if (cfg.valid & cfg.ready)
        begin
            case (cfg.index)
                REG_PATTERN_LENGTH: len_next         = cfg.data[LEN_W-1:0];
                REG_PATTERN_0_7:    pat_word_next[0] = cfg.data;
                REG_PATTERN_8_15:   pat_word_next[1] = cfg.data;
                REG_PATTERN_16_23:  pat_word_next[2] = cfg.data;
                REG_PATTERN_24_31:  pat_word_next[3] = cfg.data;
                default:            len_next         = len_reg;
            endcase
        end
    end

    // text state update
    always_comb
    begin
        first_next  = first_reg;
        m_next      = m_reg;
        skip_next   = skip_reg;
        count_next  = count_reg;
        count_upd   = count_reg;
        result_next = result_reg;

        if (m_cur != '0 && skip_cur == '0 && full && count_reg != COUNT_MAX)
        begin
            count_upd = count_reg + COUNT_W'(1);
        end

        if (accept)
        begin
            m_next     = m_cur;
            first_next = text_in.last_byte;
            if (m_cur == '0)
            begin
                skip_next = skip_cur;
            end
            else if (skip_cur == '0)
            begin
                skip_next = full ? '0 : shift_dec;
            end
            else
            begin
                skip_next = skip_cur - MW'(1);
            end

            if (text_in.last_byte)
            begin
                result_next = count_upd;
                count_next  = '0;
                skip_next   = '0;
            end
            else
            begin
                count_next = count_upd;
            end
        end
    end

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (count_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept & text_in.last_byte)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            for (int w = 0; w < PAT_WORDS; w++)
            begin
                pat_word_reg[w] <= '0;
            end
            first_reg     <= 1'b1;
            m_reg         <= '0;
            skip_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            pat_word_reg  <= pat_word_next;
            first_reg     <= first_next;
            m_reg         <= m_next;
            skip_reg      <= skip_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

// File: rtl/hsc_checker.sv
// hsc_checker: port-level assertions for horspool_substring_counter_core
// depends on hsc_pkg; bound to the top level at the end of this file
`default_nettype none

module hsc_checker
    import hsc_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               in_last,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [COUNT_W-1:0] out_count
);

    // a stalled count beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_count))
        else $error("count beat dropped or changed while stalled");

    // every last text beat produces a count beat next cycle
    a_last_gives_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> out_valid)
        else $error("no count after last text beat");

    // a count beat only ever follows a last text beat
    a_count_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_last))
        else $error("count beat without last text beat");

    // text is held off while a count waits at a stalled receiver
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("text accepted while count stalled");

endmodule

bind horspool_substring_counter_core hsc_checker u_hsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (text_in.valid),
    .in_ready  (text_in.ready),
    .in_last   (text_in.last_byte),
    .out_valid (count_out.valid),
    .out_ready (count_out.ready),
    .out_count (count_out.match_count)
);

`default_nettype wire
